/* sv/hsfc_pkg.sv */
// Shared types and constants for the half/single float converter.
// No dependencies; used by hsfc_conv and half_single_float_converter_core.
`timescale 1ns / 1ps
`default_nettype none

package hsfc_pkg;

    // Request codes carried on req_type
    localparam logic REQ_SINGLE_TO_HALF = 1'b0;
    localparam logic REQ_HALF_TO_SINGLE = 1'b1;

    // Half precision constants
    localparam logic [14:0] HALF_INF_MAG  = 15'h7c00;
    localparam logic [7:0]  SGL_EXP_MAX   = 8'hff;

    // Single exponent bounds for single to half
    localparam logic [7:0] SGL_EXP_DENORM_LO = 8'd103;  // smallest half denormal
    localparam logic [7:0] SGL_EXP_DENORM_HI = 8'd112;  // largest half denormal
    localparam logic [7:0] SGL_EXP_NORMAL_HI = 8'd142;  // largest half normal
    localparam logic [7:0] SGL_EXP_BIAS_DIFF = 8'd112;  // 127 - 15

    // Converted word with its half classification
    typedef struct packed {
        logic [31:0] result_bits;
        logic        half_is_nan;
        logic        half_is_infinity;
        logic        half_sign;
    } t_conv_res;

endpackage

`default_nettype wire

/* sv/hsfc_conv.sv */
// Combinational conversion between single and half bit patterns.
// Depends on hsfc_pkg for request codes, constants and the result struct.
`timescale 1ns / 1ps
`default_nettype none

module hsfc_conv (
    input  wire logic              i_req_type,
    input  wire logic [31:0]       i_operand_bits,
    output hsfc_pkg::t_conv_res    o_res
);

    // single to half
    logic        s_sign;
    logic [7:0]  s_exp;
    logic [22:0] s_man;
    logic [14:0] s2h_mag;
    logic [7:0]  dn_one_sh;
    logic [7:0]  dn_man_sh;
    logic [10:0] dn_one;
    logic [22:0] dn_man;
    logic [7:0]  nm_exp;

    // half to single
    logic [15:0] half_in;
    logic [4:0]  h_exp;
    logic [9:0]  h_man;
    logic [3:0]  lead_pos;
    logic [3:0]  norm_sh;
    logic [9:0]  norm_man;
    logic [7:0]  dn_exp;
    logic [31:0] h2s_bits;

    logic [15:0] half_val;

    assign s_sign = i_operand_bits[31];
    assign s_exp  = i_operand_bits[30:23];
    assign s_man  = i_operand_bits[22:0];

    // Denormal: implicit one shifted right by 113-ex, mantissa by 126-ex
    assign dn_one_sh = 8'd113 - s_exp;
    assign dn_man_sh = 8'd126 - s_exp;
    assign dn_one    = 11'h400 >> dn_one_sh[3:0];
    assign dn_man    = s_man >> dn_man_sh[4:0];
    assign nm_exp    = s_exp - hsfc_pkg::SGL_EXP_BIAS_DIFF;

    always_comb begin
        if (s_exp < hsfc_pkg::SGL_EXP_DENORM_LO) begin
            s2h_mag = '0;                       // flush to zero
        end else if (s_exp <= hsfc_pkg::SGL_EXP_DENORM_HI) begin
            s2h_mag = {4'b0, dn_one} | dn_man[14:0];
        end else if (s_exp <= hsfc_pkg::SGL_EXP_NORMAL_HI) begin
            s2h_mag = {nm_exp[4:0], s_man[22:13]};
        end else if (s_exp != hsfc_pkg::SGL_EXP_MAX) begin
            s2h_mag = hsfc_pkg::HALF_INF_MAG;   // overflow
        end else begin
            s2h_mag = hsfc_pkg::HALF_INF_MAG | {5'b0, s_man[22:13]};
        end
    end

    assign half_in = i_operand_bits[15:0];
    assign h_exp   = half_in[14:10];
    assign h_man   = half_in[9:0];

    // Leading one of a denormal mantissa
    always_comb begin
        lead_pos = '0;
        for (int i = 0; i < 10; i++) begin
            if (h_man[i]) begin
                lead_pos = 4'(i);
            end
        end
    end

    assign norm_sh  = 4'd10 - lead_pos;
    assign norm_man = h_man << norm_sh;
    assign dn_exp   = 8'd103 + {4'b0, lead_pos};

    always_comb begin
        if (h_exp == 5'd0) begin
            if (h_man == 10'd0) begin
                h2s_bits = {half_in[15], 31'b0};
            end else begin
                h2s_bits = {half_in[15], dn_exp, norm_man, 13'b0};
            end
        end else if (h_exp == 5'h1f) begin
            h2s_bits = {half_in[15], hsfc_pkg::SGL_EXP_MAX, h_man, 13'b0};
        end else begin
            h2s_bits = {half_in[15], {3'b0, h_exp} + hsfc_pkg::SGL_EXP_BIAS_DIFF,
                        h_man, 13'b0};
        end
    end

    always_comb begin
        if (i_req_type == hsfc_pkg::REQ_SINGLE_TO_HALF) begin
            half_val          = {s_sign, s2h_mag};
            o_res.result_bits = {16'b0, s_sign, s2h_mag};
        end else begin
            half_val          = half_in;
            o_res.result_bits = h2s_bits;
        end
        o_res.half_is_nan      = half_val[14:0] > hsfc_pkg::HALF_INF_MAG;
        o_res.half_is_infinity = half_val[14:0] == hsfc_pkg::HALF_INF_MAG;
        o_res.half_sign        = half_val[15];
    end

endmodule

`default_nettype wire

/* sv/half_single_float_converter_core.sv */
// Top level of the half/single float converter: input register, conversion
// logic and result register. Depends on hsfc_pkg and hsfc_conv.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input channel (i_valid / o_stall) carries one word: i_req_type selects
//   single to half (0) or half to single (1), i_operand_bits the pattern.
//   Output channel (o_valid / i_stall) returns one word per input word:
//   o_result_bits plus the half classification flags and sign.
//   A word is taken at a rising edge with valid high and stall low.
// Pipeline: two register stages. The accepted word lands in the input register
//   at the accepting edge; combinational conversion logic feeds the result
//   register, which loads whenever it is empty or being drained.
// Throughput: one word per cycle while the receiver does not stall;
//   both registers advance together whenever the output is not held.
// Stall: while the receiver stalls, the result register holds its word and
//   the input register still fills if empty, so one more word is taken.
//   o_stall rises only when both registers are occupied and the result is
//   stalled.
// Reset: i_rst_n low, sampled on i_clk, empties both registers; payload
//   registers keep whatever they held.
module half_single_float_converter_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_stall,
    input  wire logic        i_req_type,
    input  wire logic [31:0] i_operand_bits,
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic [31:0] o_result_bits,
    output      logic        o_half_is_nan,
    output      logic        o_half_is_infinity,
    output      logic        o_half_sign
);

    logic                r_in_valid;
    logic                r_req_type;
    logic [31:0]         r_operand_bits;
    logic                r_out_valid;
    hsfc_pkg::t_conv_res r_res;
    hsfc_pkg::t_conv_res n_res;

    logic out_load;
    logic in_load;

    // Result register may load when empty or being drained this cycle
    assign out_load = !r_out_valid || !i_stall;
    // Input register may load when empty or moving into the result register
    assign in_load  = !r_in_valid || out_load;
    assign o_stall  = !in_load;

    hsfc_conv u_conv (
        .i_req_type     (r_req_type),
        .i_operand_bits (r_operand_bits),
        .o_res          (n_res)
    );

    // Control: advance valid bits, clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload: hold while stalled, no reset
    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_req_type     <= i_req_type;
            r_operand_bits <= i_operand_bits;
        end
        if (out_load && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_result_bits      = r_res.result_bits;
    assign o_half_is_nan      = r_res.half_is_nan;
    assign o_half_is_infinity = r_res.half_is_infinity;
    assign o_half_sign        = r_res.half_sign;

endmodule

`default_nettype wire

/* verif/tb_half_single_float_converter_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for half_single_float_converter_core: directed edge cases and
// random words in both directions, under several traffic patterns on each channel.
// Depends on hsfc_pkg and the converter RTL.

module tb_half_single_float_converter_core;

    localparam int CLK_HALF       = 4;     // 8 ns period
    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_WORDS    = 125;

    typedef struct packed {
        logic        req_type;
        logic [31:0] operand_bits;
    } t_conv_req;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        i_req_type     = 1'b0;
    logic [31:0] i_operand_bits = '0;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_result_bits;
    logic        o_half_is_nan;
    logic        o_half_is_infinity;
    logic        o_half_sign;

    // Words waiting to be driven, and converted words waiting to come out
    t_conv_req             operand_fifo[$];
    hsfc_pkg::t_conv_res   predicted_results[$];

    // Traffic shaping, in percent per cycle
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    bit          word_taken = 1'b0;
    int          stalled_cycles = 0;
    int          mismatch_count = 0;
    int          results_checked = 0;
    int          narrowed_count = 0;
    int          widened_count = 0;

    half_single_float_converter_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_req_type         (i_req_type),
        .i_operand_bits     (i_operand_bits),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_result_bits      (o_result_bits),
        .o_half_is_nan      (o_half_is_nan),
        .o_half_is_infinity (o_half_is_infinity),
        .o_half_sign        (o_half_sign)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Single to half, truncating. Exponents below the half denormal range flush
    // to signed zero; above the normal range saturate to infinity; inf and NaN
    // keep only the top ten mantissa bits.
    function automatic logic [15:0] narrow_to_half(input logic [31:0] v);
        logic [7:0]  ex;
        logic [22:0] man;
        logic [14:0] mag;
        logic [14:0] lead;
        logic [14:0] frac;
        int          t;
        ex  = v[30:23];
        man = v[22:0];
        if (ex < hsfc_pkg::SGL_EXP_DENORM_LO) begin
            mag = '0;
        end else if (ex <= hsfc_pkg::SGL_EXP_DENORM_HI) begin
            // implicit one lands at bit (ex - 103), mantissa follows below it
            t    = 127 - int'(ex);
            lead = 15'h0400 >> (t - 14);
            frac = 15'(man >> (t - 1));
            mag  = lead + frac;
        end else if (ex <= hsfc_pkg::SGL_EXP_NORMAL_HI) begin
            mag = {ex[4:0] - hsfc_pkg::SGL_EXP_BIAS_DIFF[4:0], man[22:13]};
        end else if (ex != hsfc_pkg::SGL_EXP_MAX) begin
            mag = hsfc_pkg::HALF_INF_MAG;
        end else begin
            mag = hsfc_pkg::HALF_INF_MAG + {5'd0, man[22:13]};
        end
        return {v[31], mag};
    endfunction

    // Half to single, exact. Denormals are renormalized; NaN payloads carry over.
    function automatic logic [31:0] widen_to_single(input logic [15:0] h);
        logic [4:0] ex;
        logic [9:0] man;
        logic [7:0] sexp;
        int         p;
        ex  = h[14:10];
        man = h[9:0];
        if (ex == 5'd0) begin
            if (man == '0) begin
                return {h[15], 31'd0};
            end
            p = 9;
            while (!man[p]) begin
                p--;
            end
            // shift the leading one out of the ten-bit field
            man  = man << (10 - p);
            sexp = 8'(int'(hsfc_pkg::SGL_EXP_DENORM_LO) + p);
            return {h[15], sexp, man, 13'd0};
        end
        if (ex == 5'h1f) begin
            return {h[15], hsfc_pkg::SGL_EXP_MAX, man, 13'd0};
        end
        sexp = {3'd0, ex} + hsfc_pkg::SGL_EXP_BIAS_DIFF;
        return {h[15], sexp, man, 13'd0};
    endfunction

    function automatic hsfc_pkg::t_conv_res convert_word(input t_conv_req w);
        hsfc_pkg::t_conv_res r;
        logic [15:0]         h;
        if (w.req_type == hsfc_pkg::REQ_SINGLE_TO_HALF) begin
            h             = narrow_to_half(w.operand_bits);
            r.result_bits = {16'd0, h};
        end else begin
            // upper operand bits are ignored for half input
            h             = w.operand_bits[15:0];
            r.result_bits = widen_to_single(h);
        end
        r.half_is_nan      = h[14:0] > hsfc_pkg::HALF_INF_MAG;
        r.half_is_infinity = h[14:0] == hsfc_pkg::HALF_INF_MAG;
        r.half_sign        = h[15];
        return r;
    endfunction

    task automatic add_word(input logic req, input logic [31:0] bits);
        t_conv_req w;
        w.req_type     = req;
        w.operand_bits = bits;
        operand_fifo.push_back(w);
    endtask

    // Bias exponents toward the interesting bands; full-random words keep
    // every bit toggling.
    task automatic queue_random_words(input int count);
        t_conv_req w;
        int        pick;
        for (int n = 0; n < count; n++) begin
            w.req_type     = 1'($urandom_range(0, 1));
            w.operand_bits = $urandom;
            pick           = $urandom_range(0, 9);
            if (w.req_type == hsfc_pkg::REQ_SINGLE_TO_HALF) begin
                if (pick >= 2 && pick <= 7) begin
                    w.operand_bits[30:23] = 8'($urandom_range(101, 144));
                end else if (pick == 8) begin
                    w.operand_bits[30:23] = hsfc_pkg::SGL_EXP_MAX;
                    // payload only in the low bits: NaN collapses to infinity
                    if ($urandom_range(0, 1) == 1) begin
                        w.operand_bits[22:13] = '0;
                    end
                end
            end else begin
                if (pick <= 2) begin
                    w.operand_bits[14:10] = 5'd0;
                end else if (pick == 3) begin
                    w.operand_bits[14:10] = 5'h1f;
                end
            end
            operand_fifo.push_back(w);
        end
    endtask

    // Hold the sender until every queued word is through and checked
    task automatic wait_until_drained();
        while (operand_fifo.size() != 0 || i_valid || predicted_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Driver: change inputs at the falling edge. Advance to the next word only
    // after the current one was taken; otherwise hold valid and payload.
    always @(negedge i_clk) begin : driver
        t_conv_req w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            if (word_taken || !i_valid) begin
                if (operand_fifo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    w = operand_fifo.pop_front();
                    i_valid        <= 1'b1;
                    i_req_type     <= w.req_type;
                    i_operand_bits <= w.operand_bits;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: sample both handshakes at the rising edge. Check the outgoing
    // word first, then predict the incoming one, so order never matters.
    always @(posedge i_clk) begin : monitor
        hsfc_pkg::t_conv_res want;
        t_conv_req           taken;
        bit                  moved;
        moved      = 1'b0;
        word_taken = i_rst_n && i_valid && !o_stall;

        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            moved = 1'b1;
            if (predicted_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("[%0t] unexpected result word %h", $realtime, o_result_bits);
                end
            end else begin
                want = predicted_results.pop_front();
                results_checked++;
                if (o_result_bits !== want.result_bits
                        || o_half_is_nan !== want.half_is_nan
                        || o_half_is_infinity !== want.half_is_infinity
                        || o_half_sign !== want.half_sign) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("[%0t] mismatch: expected bits %h nan %b inf %b sign %b",
                                 $realtime, want.result_bits, want.half_is_nan,
                                 want.half_is_infinity, want.half_sign);
                        $display("[%0t]           got      bits %h nan %b inf %b sign %b",
                                 $realtime, o_result_bits, o_half_is_nan,
                                 o_half_is_infinity, o_half_sign);
                    end
                end
            end
        end

        if (word_taken) begin
            moved                = 1'b1;
            taken.req_type       = i_req_type;
            taken.operand_bits   = i_operand_bits;
            predicted_results.push_back(convert_word(taken));
            if (i_req_type == hsfc_pkg::REQ_SINGLE_TO_HALF) begin
                narrowed_count++;
            end else begin
                widened_count++;
            end
        end

        // Watchdog: drop the run if nothing moves for too long
        if (moved || !i_rst_n) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
        end
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_half_single_float_converter_core failed");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: single to half across zero, normal, denormal and saturation bands
        add_word(hsfc_pkg::REQ_SINGLE_TO_HALF, 32'h0000_0000);  // +0
        add_word(hsfc_pkg::REQ_SINGLE_TO_HALF, 32'h8000_0000);  // -0
        add_word(hsfc_pkg::REQ_SINGLE_TO_HALF, 32'h3f80_0000);  // 1.0
        add_word(hsfc_pkg::REQ_SINGLE_TO_HALF, 32'h477f_e000);  // largest half normal
        add_word(hsfc_pkg::REQ_SINGLE_TO_HALF, 32'hc780_0000);  // -65536 overflows
        add_word(hsfc_pkg::REQ_SINGLE_TO_HALF, 32'h7f7f_ffff);  // largest single finite
        add_word(hsfc_pkg::REQ_SINGLE_TO_HALF, 32'hff80_0000);  // -inf
        add_word(hsfc_pkg::REQ_SINGLE_TO_HALF, 32'h7fc0_0000);  // quiet NaN
        add_word(hsfc_pkg::REQ_SINGLE_TO_HALF, 32'h7f80_0001);  // NaN with low payload only
        add_word(hsfc_pkg::REQ_SINGLE_TO_HALF, 32'h3380_0000);  // smallest half denormal
        add_word(hsfc_pkg::REQ_SINGLE_TO_HALF, 32'h337f_ffff);  // just under it, flushes
        add_word(hsfc_pkg::REQ_SINGLE_TO_HALF, 32'h387f_ffff);  // top of denormal band
        add_word(hsfc_pkg::REQ_SINGLE_TO_HALF, 32'h3880_0000);  // smallest half normal

        // Directed: half to single, with junk in the ignored upper bits
        add_word(hsfc_pkg::REQ_HALF_TO_SINGLE, 32'hffff_0000);
        add_word(hsfc_pkg::REQ_HALF_TO_SINGLE, 32'h0000_8000);
        add_word(hsfc_pkg::REQ_HALF_TO_SINGLE, 32'h0000_0001);
        add_word(hsfc_pkg::REQ_HALF_TO_SINGLE, 32'h0000_03ff);
        add_word(hsfc_pkg::REQ_HALF_TO_SINGLE, 32'h0000_0400);
        add_word(hsfc_pkg::REQ_HALF_TO_SINGLE, 32'h0000_7bff);
        add_word(hsfc_pkg::REQ_HALF_TO_SINGLE, 32'h0000_7c00);
        add_word(hsfc_pkg::REQ_HALF_TO_SINGLE, 32'h0000_fc00);
        add_word(hsfc_pkg::REQ_HALF_TO_SINGLE, 32'h0000_7e00);
        add_word(hsfc_pkg::REQ_HALF_TO_SINGLE, 32'h0000_7c01);
        add_word(hsfc_pkg::REQ_HALF_TO_SINGLE, 32'habcd_8200);
        wait_until_drained();

        // Random: full throughput, then sender gaps, receiver stalls, and both
        queue_random_words(PHASE_WORDS);
        wait_until_drained();

        send_idle_pct  = 58;
        recv_stall_pct = 0;
        queue_random_words(PHASE_WORDS);
        wait_until_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 58;
        queue_random_words(PHASE_WORDS);
        wait_until_drained();

        send_idle_pct  = 8;
        recv_stall_pct = 8;
        queue_random_words(PHASE_WORDS);
        wait_until_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predicted_results.size() != 0) begin
            mismatch_count += predicted_results.size();
            $display("%0d predicted words never came out", predicted_results.size());
        end

        $display("converted %0d words (%0d single to half, %0d half to single), %0d checked",
                 narrowed_count + widened_count, narrowed_count, widened_count,
                 results_checked);
        $display("traffic: full rate, sender gaps, receiver stalls, mixed; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_half_single_float_converter_core passed");
        end else begin
            $display("tb_half_single_float_converter_core failed");
        end
        $finish;
    end

endmodule

/* half_single_float_converter_core.f */
sv/hsfc_pkg.sv
sv/hsfc_conv.sv
sv/half_single_float_converter_core.sv
verif/tb_half_single_float_converter_core.sv
